FILE: rtl/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg
// widths, word types and shared constants of the triangle unit normal block
// ----------------------------------------------------------------------------
package tun_pkg;

    localparam int COORD_WIDTH      = 32;
    localparam int NORMAL_FRAC_BITS = 30;

    localparam int FIELD_W = 32;
    localparam int OUT_W   = 32;
    localparam int AXES    = 3;

    localparam int EDGE_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * EDGE_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W   = CROSS_W - 1;
    localparam int LIMB_W  = (MAG_W + 1) / 2;
    localparam int HIGH_W  = MAG_W - LIMB_W;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int REM_W   = SUM_W + NORMAL_FRAC_BITS + 6;
    localparam int NSTEP   = NORMAL_FRAC_BITS + 2;
    localparam int Q_W     = NSTEP;

    typedef logic signed [EDGE_W-1:0]  edge_vec_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [CROSS_W-1:0] cross_t;

    typedef struct packed {
        logic [AXES-1:0][REM_W-1:0] rem;
        logic [AXES-1:0][REM_W-1:0] acc;
        logic [AXES-1:0][Q_W-1:0]   quo;
        logic [REM_W-1:0]           sum;
        logic [REM_W-1:0]           sum3;
        logic [AXES-1:0]            neg;
        logic                       degen;
    } root_word_t;

    typedef struct packed {
        logic [AXES-1:0][OUT_W-1:0] nrm;
        logic                       degen;
    } result_t;

endpackage

FILE: rtl/tun_if.sv
// ----------------------------------------------------------------------------
// tun_in_if / tun_out_if
// valid/ready channels for triangle words and normal words
// ----------------------------------------------------------------------------
interface tun_in_if import tun_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] p1_x;
    logic [FIELD_W-1:0] p1_y;
    logic [FIELD_W-1:0] p1_z;
    logic [FIELD_W-1:0] p2_x;
    logic [FIELD_W-1:0] p2_y;
    logic [FIELD_W-1:0] p2_z;
    logic [FIELD_W-1:0] p3_x;
    logic [FIELD_W-1:0] p3_y;
    logic [FIELD_W-1:0] p3_z;

    modport source (
        output valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
        input  ready
    );
    modport sink (
        input  valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
        output ready
    );
endinterface

interface tun_out_if import tun_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic signed [OUT_W-1:0] normal_z;
    logic                    degenerate;

    modport source (
        output valid, normal_x, normal_y, normal_z, degenerate,
        input  ready
    );
    modport sink (
        input  valid, normal_x, normal_y, normal_z, degenerate,
        output ready
    );
endinterface

FILE: rtl/triangle_unit_normal.sv
// ----------------------------------------------------------------------------
// triangle_unit_normal
// unit face normal of a triangle, Q16.16 points in, Q2.30 normal out
// ----------------------------------------------------------------------------
// Takes one triangle word per cycle and gives one normal word per triangle,
// in order: eight stages form the edges, the exact cross product and its sum
// of squares, then one stage per quotient bit (32 stages) finds each component
// divided by the length, rounded to nearest with ties away from zero, and a
// last stage applies the sign into a two-word output queue. A zero cross
// product gives a zero normal with degenerate set. The whole pipeline
// holds while the output queue is full, so ready is low in every cycle that
// the queue holds two words.
module triangle_unit_normal import tun_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    tun_in_if.sink      vertices,
    tun_out_if.source   normal
);

    logic                   en;
    logic [NSTEP:0]         valid_pipe;
    root_word_t [NSTEP:0]   word_pipe;

    assign vertices.ready = en;

    tun_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .vertices  (vertices),
        .valid_out (valid_pipe[0]),
        .word_out  (word_pipe[0])
    );

    for (genvar k = 0; k < NSTEP; k++)
    begin : g_step
        tun_root_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (valid_pipe[k]),
            .word_in   (word_pipe[k]),
            .valid_out (valid_pipe[k+1]),
            .word_out  (word_pipe[k+1])
        );
    end

    tun_out_buf u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (valid_pipe[NSTEP]),
        .word_in  (word_pipe[NSTEP]),
        .en       (en),
        .normal   (normal)
    );

endmodule

FILE: rtl/tun_cross.sv
// ----------------------------------------------------------------------------
// tun_cross
// edge vectors, cross product, squares and their sum over eight stages
// ----------------------------------------------------------------------------
module tun_cross import tun_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    tun_in_if.sink      vertices,
    output logic        valid_out,
    output root_word_t  word_out
);

    logic [7:0] v_reg;

    edge_vec_t [AXES-1:0] ea_reg, eb_reg;
    edge_vec_t [AXES-1:0] ea_next, eb_next;
    prod_t [AXES-1:0] pp_reg, pm_reg;
    cross_t [AXES-1:0] n_reg;
    logic [AXES-1:0][MAG_W-1:0] mag_reg, mag_next;
    logic [AXES-1:0] neg4_reg, neg5_reg, neg6_reg, neg7_reg, neg8_reg;
    logic degen4_reg, degen5_reg, degen6_reg, degen7_reg, degen8_reg;
    logic [AXES-1:0][2*HIGH_W-1:0] hh_reg;
    logic [AXES-1:0][HIGH_W+LIMB_W-1:0] hl_reg;
    logic [AXES-1:0][2*LIMB_W-1:0] ll_reg;
    logic [AXES-1:0][SQ_W-1:0] sq_reg, sq7_reg;
    logic [SUM_W-1:0] sum_reg;
    root_word_t word_reg, word_next;

    function automatic edge_vec_t coord(input logic [FIELD_W-1:0] v);
        return EDGE_W'(signed'(v[COORD_WIDTH-1:0]));
    endfunction

    always_comb
    begin
        ea_next[0] = coord(vertices.p1_x) - coord(vertices.p2_x);
        ea_next[1] = coord(vertices.p1_y) - coord(vertices.p2_y);
        ea_next[2] = coord(vertices.p1_z) - coord(vertices.p2_z);
        eb_next[0] = coord(vertices.p2_x) - coord(vertices.p3_x);
        eb_next[1] = coord(vertices.p2_y) - coord(vertices.p3_y);
        eb_next[2] = coord(vertices.p2_z) - coord(vertices.p3_z);
    end

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            mag_next[i] = n_reg[i][CROSS_W-1] ? MAG_W'(-n_reg[i]) : MAG_W'(n_reg[i]);
        end
    end

    always_comb
    begin
        word_next.sum   = REM_W'(sum_reg);
        word_next.sum3  = (REM_W'(sum_reg) << 1) + REM_W'(sum_reg);
        word_next.neg   = neg7_reg;
        word_next.degen = degen7_reg;
        for (int i = 0; i < AXES; i++)
        begin
            word_next.rem[i] = REM_W'(sq7_reg[i]);
            word_next.acc[i] = REM_W'(sum_reg);
            word_next.quo[i] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[6:0], vertices.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ea_reg <= ea_next;
            eb_reg <= eb_next;

            pp_reg[0] <= ea_reg[1] * eb_reg[2];
            pm_reg[0] <= ea_reg[2] * eb_reg[1];
            pp_reg[1] <= ea_reg[2] * eb_reg[0];
            pm_reg[1] <= ea_reg[0] * eb_reg[2];
            pp_reg[2] <= ea_reg[0] * eb_reg[1];
            pm_reg[2] <= ea_reg[1] * eb_reg[0];

            for (int i = 0; i < AXES; i++)
            begin
                n_reg[i] <= CROSS_W'(pp_reg[i]) - CROSS_W'(pm_reg[i]);
            end

            mag_reg <= mag_next;
            for (int i = 0; i < AXES; i++)
            begin
                neg4_reg[i] <= n_reg[i][CROSS_W-1];
            end
            degen4_reg <= (n_reg[0] == '0) && (n_reg[1] == '0) && (n_reg[2] == '0);

            for (int i = 0; i < AXES; i++)
            begin
                hh_reg[i] <= mag_reg[i][MAG_W-1:LIMB_W] * mag_reg[i][MAG_W-1:LIMB_W];
                hl_reg[i] <= mag_reg[i][MAG_W-1:LIMB_W] * mag_reg[i][LIMB_W-1:0];
                ll_reg[i] <= mag_reg[i][LIMB_W-1:0] * mag_reg[i][LIMB_W-1:0];
            end
            neg5_reg   <= neg4_reg;
            degen5_reg <= degen4_reg;

            for (int i = 0; i < AXES; i++)
            begin
                sq_reg[i] <= (SQ_W'(hh_reg[i]) << (2 * LIMB_W))
                           + (SQ_W'(hl_reg[i]) << (LIMB_W + 1))
                           + SQ_W'(ll_reg[i]);
            end
            neg6_reg   <= neg5_reg;
            degen6_reg <= degen5_reg;

            sum_reg    <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            sq7_reg    <= sq_reg;
            neg7_reg   <= neg6_reg;
            degen7_reg <= degen6_reg;

            word_reg   <= word_next;
            neg8_reg   <= neg7_reg;
            degen8_reg <= degen7_reg;
        end
    end

    assign valid_out = v_reg[7];
    always_comb
    begin
        word_out       = word_reg;
        word_out.neg   = neg8_reg;
        word_out.degen = degen8_reg;
    end

endmodule

FILE: rtl/tun_root_step.sv
// ----------------------------------------------------------------------------
// tun_root_step
// one quotient bit of |n_i| / sqrt(S) for all three axes, no multiplier
// ----------------------------------------------------------------------------
module tun_root_step import tun_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        valid_in,
    input  root_word_t  word_in,
    output logic        valid_out,
    output root_word_t  word_out
);

    logic       valid_reg;
    root_word_t word_reg, word_next;

    always_comb
    begin
        logic [REM_W-1:0] diff;
        logic             take;
        word_next = word_in;
        for (int i = 0; i < AXES; i++)
        begin
            diff = word_in.rem[i] - word_in.acc[i];
            take = !diff[REM_W-1];
            word_next.rem[i] = take ? (diff << 2) : (word_in.rem[i] << 2);
            word_next.acc[i] = take ? ((word_in.acc[i] << 1) + word_in.sum3)
                                    : ((word_in.acc[i] << 1) - word_in.sum);
            word_next.quo[i] = {word_in.quo[i][Q_W-2:0], take};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign valid_out = valid_reg;
    assign word_out  = word_reg;

endmodule

FILE: rtl/tun_out_buf.sv
// ----------------------------------------------------------------------------
// tun_out_buf
// rounding and sign of each component, two-word output queue, pipeline enable
// ----------------------------------------------------------------------------
module tun_out_buf import tun_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid_in,
    input  root_word_t  word_in,
    output logic        en,
    tun_out_if.source   normal
);

    result_t          res;
    result_t [1:0]    buf_reg;
    logic [1:0]       cnt_reg, cnt_next;
    logic             wr_ptr_reg, rd_ptr_reg;
    logic             wr, rd;

    always_comb
    begin
        logic [Q_W:0]       rnd;
        logic [OUT_W-1:0]   val;
        res.degen = word_in.degen;
        for (int i = 0; i < AXES; i++)
        begin
            rnd = (Q_W + 1)'(word_in.quo[i]) + 1'b1;
            val = OUT_W'(rnd[Q_W:1]);
            if (word_in.degen)
            begin
                res.nrm[i] = '0;
            end
            else
            begin
                res.nrm[i] = word_in.neg[i] ? -val : val;
            end
        end
    end

    assign en = (cnt_reg != 2'd2);
    assign wr = en && valid_in;
    assign rd = normal.valid && normal.ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr && !rd)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!wr && rd)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            buf_reg[wr_ptr_reg] <= res;
        end
    end

    assign normal.valid      = (cnt_reg != 2'd0);
    assign normal.normal_x   = buf_reg[rd_ptr_reg].nrm[0];
    assign normal.normal_y   = buf_reg[rd_ptr_reg].nrm[1];
    assign normal.normal_z   = buf_reg[rd_ptr_reg].nrm[2];
    assign normal.degenerate = buf_reg[rd_ptr_reg].degen;

endmodule

FILE: tb/tb_triangle_unit_normal.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_triangle_unit_normal
// self-checking testbench for the triangle unit normal block
// ----------------------------------------------------------------------------
// Drives triangle words with random gaps and takes normal words with random
// stalls. Every accepted triangle is run through an exact wide-integer model
// of the edge, cross product and rounded normalization, and each normal word
// is compared field by field with the oldest prediction. Directed corners
// come first, then random triangles: full-range, small, extreme, collinear
// and coincident.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [31:0] p1_x, p1_y, p1_z;
    logic [31:0] p2_x, p2_y, p2_z;
    logic [31:0] p3_x, p3_y, p3_z;
} triangle_t;

typedef struct packed {
    logic [31:0] nx, ny, nz;
    logic        degen;
} normal_word_t;

class normal_scoreboard;
    normal_word_t pending_normals[$];
    int           errors;

    function new();
        errors = 0;
    endfunction

    static function logic [31:0] unit_component(logic signed [255:0] n,
                                                logic [255:0] s);
        logic [255:0] mag, t, t4, q, c, r;
        logic         neg;
        neg = n[255];
        mag = neg ? -n : n;
        t   = (mag * mag) << 60;
        t4  = t << 2;
        q   = 0;
        for (int b = 30; b >= 0; b--)
        begin
            c = q | (256'd1 << b);
            if (c * c * s <= t)
                q = c;
        end
        r = 2 * q + 1;
        if (r * r * s <= t4)
            q = q + 1;
        if (neg)
            q = -q;
        return q[31:0];
    endfunction

    function void note_triangle(triangle_t w);
        logic signed [255:0] ax, ay, az, bx, by, bz, nx, ny, nz;
        logic [255:0]        s;
        normal_word_t        e;
        ax = $signed(w.p1_x) - $signed(w.p2_x);
        ay = $signed(w.p1_y) - $signed(w.p2_y);
        az = $signed(w.p1_z) - $signed(w.p2_z);
        bx = $signed(w.p2_x) - $signed(w.p3_x);
        by = $signed(w.p2_y) - $signed(w.p3_y);
        bz = $signed(w.p2_z) - $signed(w.p3_z);
        nx = ay * bz - az * by;
        ny = az * bx - ax * bz;
        nz = ax * by - ay * bx;
        s  = nx * nx + ny * ny + nz * nz;
        if (s == 0)
        begin
            e = '{nx: 0, ny: 0, nz: 0, degen: 1'b1};
        end
        else
        begin
            e.nx    = unit_component(nx, s);
            e.ny    = unit_component(ny, s);
            e.nz    = unit_component(nz, s);
            e.degen = 1'b0;
        end
        pending_normals.push_back(e);
    endfunction

    function void check_normal(normal_word_t got);
        normal_word_t e;
        if (pending_normals.size() == 0)
        begin
            $display("%0t: unexpected normal word %h", $time, got);
            errors++;
            return;
        end
        e = pending_normals.pop_front();
        if (got.nx !== e.nx)
        begin
            $display("%0t: normal_x expected %h actual %h", $time, e.nx, got.nx);
            errors++;
        end
        if (got.ny !== e.ny)
        begin
            $display("%0t: normal_y expected %h actual %h", $time, e.ny, got.ny);
            errors++;
        end
        if (got.nz !== e.nz)
        begin
            $display("%0t: normal_z expected %h actual %h", $time, e.nz, got.nz);
            errors++;
        end
        if (got.degen !== e.degen)
        begin
            $display("%0t: degenerate expected %b actual %b", $time, e.degen, got.degen);
            errors++;
        end
    endfunction
endclass

module tb_triangle_unit_normal;
    import tun_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 60;
    localparam int N_RANDOM    = 450;

    logic clk;
    logic rst_n;
    logic quiet;
    int   idle_cycles;
    int   stall_left;

    normal_scoreboard sb;

    tun_in_if  vertices_if ();
    tun_out_if normal_if ();

    triangle_unit_normal uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .vertices (vertices_if),
        .normal   (normal_if)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // sink side stalls
    always @(negedge clk)
    begin
        if (quiet || !rst_n)
        begin
            normal_if.ready <= 1'b1;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            normal_if.ready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            normal_if.ready <= 1'b0;
            stall_left = $urandom_range(1, 8) - 1;
        end
        else
        begin
            normal_if.ready <= 1'b1;
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (vertices_if.valid && vertices_if.ready)
                sb.note_triangle({vertices_if.p1_x, vertices_if.p1_y, vertices_if.p1_z,
                                  vertices_if.p2_x, vertices_if.p2_y, vertices_if.p2_z,
                                  vertices_if.p3_x, vertices_if.p3_y, vertices_if.p3_z});
            if (normal_if.valid && normal_if.ready)
                sb.check_normal({normal_if.normal_x, normal_if.normal_y,
                                 normal_if.normal_z, normal_if.degenerate});
            if ((vertices_if.valid && vertices_if.ready)
                || (normal_if.valid && normal_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_triangle(triangle_t w);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            vertices_if.valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        vertices_if.valid = 1'b1;
        {vertices_if.p1_x, vertices_if.p1_y, vertices_if.p1_z,
         vertices_if.p2_x, vertices_if.p2_y, vertices_if.p2_z,
         vertices_if.p3_x, vertices_if.p3_y, vertices_if.p3_z} = w;
        do
            @(posedge clk);
        while (!vertices_if.ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        vertices_if.valid = 1'b0;
        while (sb.pending_normals.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [31:0] pick_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $unsigned($signed($urandom_range(0, 2047)) - 1024);
            2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return $unsigned($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    function automatic triangle_t random_triangle();
        triangle_t   w;
        int          kind;
        int          k;
        logic [31:0] d [3];
        logic [31:0] b [3];
        kind = $urandom_range(0, 9);
        if (kind < 7)
        begin
            int mode;
            mode = (kind < 4) ? 0 : (kind < 6) ? 1 : $urandom_range(0, 3);
            w = {pick_coord(mode), pick_coord(mode), pick_coord(mode),
                 pick_coord(mode), pick_coord(mode), pick_coord(mode),
                 pick_coord(mode), pick_coord(mode), pick_coord(mode)};
        end
        else
        begin
            // collinear or coincident points
            for (int i = 0; i < 3; i++)
            begin
                b[i] = pick_coord(3);
                d[i] = (kind == 9) ? 32'd0 : pick_coord(1);
            end
            k = $urandom_range(0, 6) - 3;
            w = {b[0], b[1], b[2],
                 b[0] + d[0], b[1] + d[1], b[2] + d[2],
                 b[0] + k * d[0], b[1] + k * d[1], b[2] + k * d[2]};
        end
        return w;
    endfunction

    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] PMAX = 32'h7fff_ffff;
    localparam logic [31:0] NMIN = 32'h8000_0000;

    initial
    begin
        triangle_t directed [$];
        sb = new();
        rst_n = 1'b0;
        quiet = 1'b0;
        idle_cycles = 0;
        stall_left = 0;
        vertices_if.valid = 1'b0;
        {vertices_if.p1_x, vertices_if.p1_y, vertices_if.p1_z,
         vertices_if.p2_x, vertices_if.p2_y, vertices_if.p2_z,
         vertices_if.p3_x, vertices_if.p3_y, vertices_if.p3_z} = '0;
        normal_if.ready = 1'b1;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed.push_back('0);
        directed.push_back({ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE});
        directed.push_back({32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0});
        directed.push_back({32'd0, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE});
        directed.push_back({32'd0, 32'd0, 32'd0, 32'd0, 32'd0, ONE, ONE, 32'd0, 32'd0});
        directed.push_back({ONE, ONE, ONE, 32'd0, 32'd0, 32'd0, -ONE, -ONE, -ONE});
        directed.push_back({PMAX, NMIN, PMAX, NMIN, PMAX, NMIN, PMAX, PMAX, NMIN});
        directed.push_back({NMIN, NMIN, NMIN, PMAX, PMAX, PMAX, NMIN, PMAX, NMIN});
        directed.push_back({PMAX, NMIN, NMIN, NMIN, PMAX, NMIN, NMIN, NMIN, PMAX});
        directed.push_back({NMIN, PMAX, PMAX, PMAX, NMIN, PMAX, PMAX, PMAX, NMIN});
        directed.push_back({PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, NMIN, NMIN, NMIN});
        directed.push_back({32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1});
        directed.push_back({32'd0, 32'd0, 32'd0, 32'd3, 32'd0, 32'd0, 32'd3, 32'd4, 32'd0});
        directed.push_back({32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd1, 32'd1, 32'd0});
        directed.push_back({32'hffffffff, 32'd0, 32'd0, 32'd0, 32'hffffffff, 32'd0,
                            32'd0, 32'd0, 32'hffffffff});
        directed.push_back({32'd0, 32'd0, 32'd0, ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE});
        directed.push_back({32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678,
                            32'haaaa_aaaa, 32'h5555_5555, 32'hedcb_a987,
                            32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'h0000_ffff});
        foreach (directed[i])
            send_triangle(directed[i]);

        wait_drained();

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 2)
                wait_drained();
            if (i == N_RANDOM - 60)
                quiet = 1'b1;
            send_triangle(random_triangle());
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.pending_normals.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

FILE: triangle_unit_normal.f
rtl/tun_pkg.sv
rtl/tun_if.sv
rtl/tun_cross.sv
rtl/tun_root_step.sv
rtl/tun_out_buf.sv
rtl/triangle_unit_normal.sv
tb/tb_triangle_unit_normal.sv
